/* sv/rtcc_pkg.sv */
// ----------------------------------------------------------------------------
// rtcc_pkg - RTC calendar counter shared definitions
// Operation codes, date and time-of-day records, reset values and the
// Gregorian month-length helpers.
// ----------------------------------------------------------------------------
package rtcc_pkg;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_DATE = 2'd1;
  localparam logic [1:0] OP_SET_TIME = 2'd2;

  localparam logic [15:0] RESET_YEAR  = 16'd2012;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [4:0]  RESET_DAY   = 5'd1;

  localparam logic [4:0] LAST_HOUR   = 5'd23;
  localparam logic [5:0] LAST_MINUTE = 6'd59;
  localparam logic [5:0] LAST_SECOND = 6'd59;
  localparam logic [3:0] LAST_MONTH  = 4'd12;

  // y is a multiple of 25 iff y * inverse(25) mod 2^16 <= floor(65535 / 25)
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } cal_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // Leap: multiple of 4 and (not of 100, or of 400). With y a multiple of 4,
  // "of 100" reduces to "of 25" and "of 400" to "of 16".
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [15:0] y, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2: begin
        len = is_leap(y) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

/* sv/rtcc_step.sv */
// ----------------------------------------------------------------------------
// rtcc_step - RTC calendar next-state logic
// Combinational update of date and time of day for one operation.
// ----------------------------------------------------------------------------
module rtcc_step (
  input  logic [1:0]      op,
  input  rtcc_pkg::cal_t  cal,
  input  rtcc_pkg::tod_t  tod,
  input  logic            time_set,
  input  logic [15:0]     year_in,
  input  logic [3:0]      month_in,
  input  logic [4:0]      day_in,
  input  logic [4:0]      hour_in,
  input  logic [5:0]      minute_in,
  input  logic [5:0]      second_in,
  output rtcc_pkg::cal_t  cal_next,
  output rtcc_pkg::tod_t  tod_next,
  output logic            time_set_next,
  output logic            status_next
);

  logic        is_set_date;
  logic [15:0] len_year;
  logic [3:0]  len_month;
  logic [4:0]  mlen;
  logic        date_bad;
  logic        sec_wrap;
  logic        min_wrap;
  logic        day_wrap;
  rtcc_pkg::cal_t cal_adv;
  rtcc_pkg::tod_t tod_tick;
  rtcc_pkg::tod_t tod_load;

  // One month-length lookup, shared by the tick and the set-date check
  assign is_set_date = (op == rtcc_pkg::OP_SET_DATE);
  assign len_year    = is_set_date ? year_in  : cal.year;
  assign len_month   = is_set_date ? month_in : cal.month;
  assign mlen        = rtcc_pkg::month_len(len_year, len_month);

  assign date_bad = (month_in == 4'd0) || (month_in > rtcc_pkg::LAST_MONTH) ||
                    (day_in == 5'd0) || (day_in > mlen);

  // Seconds, minutes, hours ripple
  assign sec_wrap = (tod.second >= rtcc_pkg::LAST_SECOND);
  assign min_wrap = sec_wrap && (tod.minute >= rtcc_pkg::LAST_MINUTE);
  assign day_wrap = min_wrap && (tod.hour >= rtcc_pkg::LAST_HOUR);

  always_comb begin
    tod_tick.second = sec_wrap ? 6'd0 : 6'(tod.second + 6'd1);
    tod_tick.minute = min_wrap ? 6'd0 : (sec_wrap ? 6'(tod.minute + 6'd1) : tod.minute);
    tod_tick.hour   = day_wrap ? 5'd0 : (min_wrap ? 5'(tod.hour + 5'd1) : tod.hour);
  end

  always_comb begin
    cal_adv = cal;
    if (cal.day < mlen) begin
      cal_adv.day = 5'(cal.day + 5'd1);
    end else if (cal.month >= rtcc_pkg::LAST_MONTH) begin
      cal_adv.day   = 5'd1;
      cal_adv.month = 4'd1;
      cal_adv.year  = 16'(cal.year + 16'd1);
    end else begin
      cal_adv.day   = 5'd1;
      cal_adv.month = 4'(cal.month + 4'd1);
    end
  end

  // Clamp loaded time fields to their last legal value
  always_comb begin
    tod_load.hour   = (hour_in   > rtcc_pkg::LAST_HOUR)   ? rtcc_pkg::LAST_HOUR   : hour_in;
    tod_load.minute = (minute_in > rtcc_pkg::LAST_MINUTE) ? rtcc_pkg::LAST_MINUTE : minute_in;
    tod_load.second = (second_in > rtcc_pkg::LAST_SECOND) ? rtcc_pkg::LAST_SECOND : second_in;
  end

  always_comb begin
    cal_next      = cal;
    tod_next      = tod;
    time_set_next = time_set;
    status_next   = 1'b0;
    case (op)
      rtcc_pkg::OP_TICK: begin
        tod_next = tod_tick;
        if (day_wrap) begin
          cal_next = cal_adv;
        end
      end
      rtcc_pkg::OP_SET_DATE: begin
        if (date_bad) begin
          status_next = 1'b1;
        end else begin
          cal_next.year  = year_in;
          cal_next.month = month_in;
          cal_next.day   = day_in;
        end
      end
      rtcc_pkg::OP_SET_TIME: begin
        tod_next      = tod_load;
        time_set_next = 1'b1;
      end
      default: begin
        status_next = 1'b0;
      end
    endcase
  end

endmodule

/* sv/rtc_calendar_counter.sv */
// ----------------------------------------------------------------------------
// rtc_calendar_counter - real-time clock calendar
// Keeps a Gregorian date and a time of day; ticks, set-date and set-time
// operations each return one beat with the date, h:m:s and status.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid / in_ready    | operation, year/month/day/hour/minute/
//           |                        | second_in
//   out     | out_valid / out_ready  | year/month/day/hour/minute/second_out,
//           |                        | time_valid, status
//
// One beat in, one beat out, through the input register, then next-state
// logic into the state and the output register. Unless the output stalls,
// a beat can be taken every cycle: the input register refills as it drains.
// The time of day is held directly as hour/minute/second counters, so no
// division of a seconds count is needed on the output side.
// Reset (rst, synchronous) empties both registers and loads 2012-01-01
// 00:00:00 with time not set. A stalled output holds its beat; the input
// register then holds one more beat before in_ready drops.
// ----------------------------------------------------------------------------
module rtc_calendar_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out,
  output logic        time_valid,
  output logic        status
);

  // Input register
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [15:0] s1_year;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [4:0]  s1_hour;
  logic [5:0]  s1_minute;
  logic [5:0]  s1_second;

  // Calendar state
  rtcc_pkg::cal_t cal;
  rtcc_pkg::tod_t tod;
  logic           time_set;

  rtcc_pkg::cal_t cal_next;
  rtcc_pkg::tod_t tod_next;
  logic           time_set_next;
  logic           status_next;

  logic advance;

  // Move the held beat on whenever the output register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op     <= operation;
      s1_year   <= year_in;
      s1_month  <= month_in;
      s1_day    <= day_in;
      s1_hour   <= hour_in;
      s1_minute <= minute_in;
      s1_second <= second_in;
    end
  end

  rtcc_step u_step (
    .op            (s1_op),
    .cal           (cal),
    .tod           (tod),
    .time_set      (time_set),
    .year_in       (s1_year),
    .month_in      (s1_month),
    .day_in        (s1_day),
    .hour_in       (s1_hour),
    .minute_in     (s1_minute),
    .second_in     (s1_second),
    .cal_next      (cal_next),
    .tod_next      (tod_next),
    .time_set_next (time_set_next),
    .status_next   (status_next)
  );

  // Commit state only when the beat moves into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cal.year   <= rtcc_pkg::RESET_YEAR;
      cal.month  <= rtcc_pkg::RESET_MONTH;
      cal.day    <= rtcc_pkg::RESET_DAY;
      tod        <= '0;
      time_set   <= 1'b0;
    end else if (advance) begin
      cal      <= cal_next;
      tod      <= tod_next;
      time_set <= time_set_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      year_out   <= cal_next.year;
      month_out  <= cal_next.month;
      day_out    <= cal_next.day;
      hour_out   <= tod_next.hour;
      minute_out <= tod_next.minute;
      second_out <= tod_next.second;
      time_valid <= time_set_next;
      status     <= status_next;
    end
  end

endmodule

/* sv/rtcc_checker.sv */
// ----------------------------------------------------------------------------
// rtcc_checker - RTC calendar port checks
// Watches the top-level ports for calendar ranges, time_valid stickiness and output stalls.
// ----------------------------------------------------------------------------
module rtcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  operation,
  input logic [15:0] year_in,
  input logic [3:0]  month_in,
  input logic [4:0]  day_in,
  input logic [4:0]  hour_in,
  input logic [5:0]  minute_in,
  input logic [5:0]  second_in,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] year_out,
  input logic [3:0]  month_out,
  input logic [4:0]  day_out,
  input logic [4:0]  hour_out,
  input logic [5:0]  minute_out,
  input logic [5:0]  second_out,
  input logic        time_valid,
  input logic        status
);

  // Date on every beat has month 1..12 and day 1..31
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_out >= 4'd1) && (month_out <= 4'd12) &&
                  (day_out >= 5'd1) && (day_out <= 5'd31))
    else $error("rtcc: date out of range");

  // Time of day on every beat is legal
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour_out <= 5'd23) && (minute_out <= 6'd59) && (second_out <= 6'd59))
    else $error("rtcc: time of day out of range");

  // Once time has been set it stays set until reset
  a_time_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && out_valid && $past(out_valid && time_valid) |-> time_valid)
    else $error("rtcc: time_valid dropped");

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year_out) && $stable(month_out) &&
      $stable(day_out) && $stable(hour_out) && $stable(minute_out) &&
      $stable(second_out) && $stable(time_valid) && $stable(status))
    else $error("rtcc: stalled output changed");

endmodule

bind rtc_calendar_counter rtcc_checker u_rtcc_checker (.*);
